@@ rtl/core/cat_text_stream_formatter_defines.svh @@
// Assertion helpers for the text stream formatter.
// The macros refer to clk and rst_n of the module that uses them.
`ifndef CAT_TEXT_STREAM_FORMATTER_DEFINES_SVH
`define CAT_TEXT_STREAM_FORMATTER_DEFINES_SVH

`ifndef SYNTHESIS
`define CFT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cft: same-cycle check failed");
`define CFT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cft: next-cycle check failed");
`else
`define CFT_ASSERT_IMPL(lbl, ante, cons)
`define CFT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/cft_pkg.sv @@
package cft_pkg;

  localparam int NUMBER_DIGITS = 6;
  localparam int NUM_W         = 4 * NUMBER_DIGITS;
  localparam int NUM_CHARS     = NUMBER_DIGITS + 1;     // digits and the tab
  localparam int BODY_MAX      = 4;                     // "M-^X" is the longest
  localparam int BODY_LEN_W    = 3;
  localparam int SEQ_LEN       = NUM_CHARS + BODY_MAX;
  localparam int CNT_W         = $clog2(SEQ_LEN + 1);
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int BYTE_W        = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 1;

  // input ops
  localparam logic OP_NEW_FILE = 1'b0;
  localparam logic OP_DATA     = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_ALL       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_NONBLANK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINTING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_LINE_END    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS        = 3'd5;

  // characters
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_DASH   = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_QMARK  = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_I      = 8'h49;
  localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
  localparam logic [BYTE_W-1:0] CH_CARET  = 8'h5E;
  localparam logic [6:0]        CH_DEL7   = 7'h7F;

  localparam logic [NUM_W-1:0] LINE_ONE = NUM_W'(1);

  typedef logic [NUMBER_DIGITS-1:0][BYTE_W-1:0] num_chars_t;
  typedef logic [BODY_MAX-1:0][BYTE_W-1:0]      body_t;

  // one formatted burst, queued between front and back
  typedef struct packed {
    logic                  has_num;
    logic [NUM_W-1:0]      num;
    body_t                 body;
    logic [BODY_LEN_W-1:0] body_len;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // BCD increment, holds at all nines
  function automatic logic [NUM_W-1:0] bcd_inc(input logic [NUM_W-1:0] num);
    logic [NUM_W-1:0] res;
    logic             carry;
    logic             full;
    logic [3:0]       d;
    res   = num;
    carry = 1'b1;
    full  = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      d = num[4*i +: 4];
      if (d != 4'd9) full = 1'b0;
      if (carry) begin
        if (d == 4'd9) begin
          res[4*i +: 4] = 4'd0;
        end else begin
          res[4*i +: 4] = d + 4'd1;
          carry = 1'b0;
        end
      end
    end
    return full ? num : res;
  endfunction

  // right-aligned digits; element 0 is the most significant, sent first
  function automatic num_chars_t fmt_number(input logic [NUM_W-1:0] num);
    num_chars_t res;
    logic       started;
    logic [3:0] d;
    int         i;
    started = 1'b0;
    for (int k = 0; k < NUMBER_DIGITS; k++) begin
      i = NUMBER_DIGITS - 1 - k;
      d = num[4*i +: 4];
      if (d == 4'd0 && !started && i > 0) begin
        res[k] = CH_SPACE;
      end else begin
        started = 1'b1;
        res[k] = CH_ZERO + {4'd0, d};
      end
    end
    return res;
  endfunction

endpackage

@@ rtl/core/cft_in_if.sv @@
interface cft_in_if import cft_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [BYTE_W-1:0] byte_in;

  modport source(output valid, op, byte_in, input ready);
  modport sink(input valid, op, byte_in, output ready);
endinterface

@@ rtl/core/cft_out_if.sv @@
interface cft_out_if import cft_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source(output valid, out_byte, last, input ready);
  modport sink(input valid, out_byte, last, output ready);
endinterface

@@ rtl/core/cft_cfg_if.sv @@
interface cft_cfg_if import cft_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/core/cat_text_stream_formatter.sv @@
// Channel   Direction  Payload                  Transfer
// in_ch     in         op, byte_in              valid & ready
// out_ch    out        out_byte, last           valid & ready
// cfg_ch    in         index, data (bit 0)      valid & ready (ready always high)
//
// The front takes one item a cycle while the 4-entry queue has room; it updates
// the line counter and newline state in that cycle.
// The back sends one byte a cycle from a shift register while out_ch is ready;
// an item gives 1 to 11 output bytes, and items with no output are not queued.
// Reset (rst_n low, synchronous) clears the config registers and queue and sets the line counter to one.
// A stalled out_ch holds the output register; in_ch.ready drops when the queue fills.
`include "cat_text_stream_formatter_defines.svh"

module cat_text_stream_formatter import cft_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  cft_in_if.sink    in_ch,
  cft_out_if.source out_ch,
  cft_cfg_if.sink   cfg_ch
);

  logic      push;
  logic      pop;
  cmd_t      push_cmd;
  cmd_t      head;
  q_status_t q_stat;

  cft_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  cft_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  cft_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  `CFT_ASSERT_IMPL(a_no_overflow, push, !q_stat.full)
  `CFT_ASSERT_IMPL(a_body_nonempty, pop, head.body_len != '0)
  `CFT_ASSERT_NEXT(a_push_lands, push && !pop, !q_stat.empty)

endmodule

@@ rtl/core/cft_queue.sv @@
module cft_queue import cft_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t q_stat
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);

endmodule

@@ rtl/core/cft_front.sv @@
module cft_front import cft_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  cft_in_if.sink    in_ch,
  cft_cfg_if.sink   cfg_ch,
  input  q_status_t q_stat,
  output logic      push,
  output cmd_t      push_cmd
);

  logic number_all_r, number_nonblank_r, squeeze_blank_r;
  logic show_nonprinting_r, mark_line_end_r, show_tabs_r;

  logic [NUM_W-1:0] line_count_r, line_count_nxt;
  logic [1:0]       newline_run_r, newline_run_nxt;
  logic             at_file_start_r, at_file_start_nxt;

  logic             in_xfer;
  logic [2:0]       prior;
  logic             line_start;
  logic             is_nl;
  logic             emit;
  logic             has_num;
  body_t            body;
  logic [BODY_LEN_W-1:0] body_len;
  logic [6:0]       low7;
  logic [BYTE_W-1:0] t0, t1;
  logic [BODY_LEN_W-1:0] tlen;

  assign in_ch.ready  = !q_stat.full;
  assign cfg_ch.ready = 1'b1;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  assign prior      = {1'b0, newline_run_r} + {2'b00, at_file_start_r};
  assign line_start = (prior != 3'd0);
  assign is_nl      = (in_ch.byte_in == CH_NL);
  assign low7       = in_ch.byte_in[6:0];

  // caret form of the low seven bits
  always_comb begin
    if (low7[6:5] == 2'b00) begin
      t0   = CH_CARET;
      t1   = {3'b010, low7[4:0]};
      tlen = BODY_LEN_W'(2);
    end else if (low7 == CH_DEL7) begin
      t0   = CH_CARET;
      t1   = CH_QMARK;
      tlen = BODY_LEN_W'(2);
    end else begin
      t0   = {1'b0, low7};
      t1   = '0;
      tlen = BODY_LEN_W'(1);
    end
  end

  always_comb begin
    body     = '0;
    body_len = BODY_LEN_W'(1);
    if (is_nl) begin
      emit    = !(squeeze_blank_r && prior >= 3'd2);
      has_num = line_start && number_all_r && !number_nonblank_r;
      if (mark_line_end_r) begin
        body[0]  = CH_DOLLAR;
        body[1]  = CH_NL;
        body_len = BODY_LEN_W'(2);
      end else begin
        body[0]  = CH_NL;
      end
    end else begin
      emit    = 1'b1;
      has_num = line_start && (number_nonblank_r || number_all_r);
      if (in_ch.byte_in == CH_TAB) begin
        if (show_tabs_r) begin
          body[0]  = CH_CARET;
          body[1]  = CH_I;
          body_len = BODY_LEN_W'(2);
        end else begin
          body[0]  = CH_TAB;
        end
      end else if (show_nonprinting_r) begin
        if (in_ch.byte_in[7]) begin
          body[0]  = CH_M;
          body[1]  = CH_DASH;
          body[2]  = t0;
          body[3]  = t1;
          body_len = tlen + BODY_LEN_W'(2);
        end else begin
          body[0]  = t0;
          body[1]  = t1;
          body_len = tlen;
        end
      end else begin
        body[0] = in_ch.byte_in;
      end
    end
  end

  always_comb begin
    line_count_nxt    = line_count_r;
    newline_run_nxt   = newline_run_r;
    at_file_start_nxt = at_file_start_r;
    push              = 1'b0;
    if (in_xfer) begin
      if (in_ch.op == OP_NEW_FILE) begin
        line_count_nxt    = LINE_ONE;
        newline_run_nxt   = 2'd0;
        at_file_start_nxt = 1'b1;
      end else begin
        if (is_nl) begin
          if (newline_run_r != 2'd3) newline_run_nxt = newline_run_r + 2'd1;
        end else begin
          newline_run_nxt   = 2'd0;
          at_file_start_nxt = 1'b0;
        end
        push = emit;
        if (emit && has_num) line_count_nxt = bcd_inc(line_count_r);
      end
    end
  end

  assign push_cmd.has_num  = has_num;
  assign push_cmd.num      = line_count_r;
  assign push_cmd.body     = body;
  assign push_cmd.body_len = body_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r    <= LINE_ONE;
      newline_run_r   <= 2'd0;
      at_file_start_r <= 1'b1;
    end else begin
      line_count_r    <= line_count_nxt;
      newline_run_r   <= newline_run_nxt;
      at_file_start_r <= at_file_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_all_r       <= 1'b0;
      number_nonblank_r  <= 1'b0;
      squeeze_blank_r    <= 1'b0;
      show_nonprinting_r <= 1'b0;
      mark_line_end_r    <= 1'b0;
      show_tabs_r        <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_NUMBER_ALL:       number_all_r       <= cfg_ch.data[0];
        REG_NUMBER_NONBLANK:  number_nonblank_r  <= cfg_ch.data[0];
        REG_SQUEEZE_BLANK:    squeeze_blank_r    <= cfg_ch.data[0];
        REG_SHOW_NONPRINTING: show_nonprinting_r <= cfg_ch.data[0];
        REG_MARK_LINE_END:    mark_line_end_r    <= cfg_ch.data[0];
        REG_SHOW_TABS:        show_tabs_r        <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/cft_back.sv @@
module cft_back import cft_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      head,
  input  q_status_t q_stat,
  output logic      pop,
  cft_out_if.source out_ch
);

  typedef logic [SEQ_LEN-1:0][BYTE_W-1:0] seq_t;

  seq_t              work_r, work_nxt;
  seq_t              load;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  load_len;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic              adv;
  logic              emit;
  num_chars_t        digits;

  assign digits = fmt_number(head.num);

  // burst image: optional number and tab, then the body
  always_comb begin
    load = '0;
    if (head.has_num) begin
      for (int k = 0; k < NUMBER_DIGITS; k++) load[k] = digits[k];
      load[NUMBER_DIGITS] = CH_TAB;
      for (int j = 0; j < BODY_MAX; j++) load[NUM_CHARS + j] = head.body[j];
    end else begin
      for (int j = 0; j < BODY_MAX; j++) load[j] = head.body[j];
    end
    load_len = CNT_W'(head.body_len) + (head.has_num ? CNT_W'(NUM_CHARS) : '0);
  end

  assign adv  = !out_valid_r || out_ch.ready;
  assign emit = adv && (rem_r != '0);
  // refill when idle or as the last byte of the current burst goes out
  assign pop  = !q_stat.empty && ((rem_r == '0) || (rem_r == CNT_W'(1) && adv));

  always_comb begin
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = work_r[0];
      out_last_nxt  = (rem_r == CNT_W'(1));
      work_nxt      = work_r >> BYTE_W;
      rem_nxt       = rem_r - CNT_W'(1);
    end
    if (pop) begin
      work_nxt = load;
      rem_nxt  = load_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last     = out_last_r;

endmodule

@@ sim/cft_stream_checker.sv @@
`timescale 1ns / 100ps

module cft_stream_checker import cft_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  cft_in_if    in_ch,
  cft_out_if   out_ch,
  cft_cfg_if   cfg_ch,
  output int   mismatches,
  output int   outstanding,
  output int   chars_checked
);

  localparam int MAX_BURST  = NUM_CHARS + BODY_MAX;
  localparam int PRINT_CAP  = 30;

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              last;
  } out_char_t;

  out_char_t expected_chars [$];

  // formatting options
  logic number_all;
  logic number_nonblank;
  logic squeeze_blank;
  logic show_nonprinting;
  logic mark_line_end;
  logic show_tabs;

  // running text state
  logic [NUM_W-1:0] line_num;
  logic [1:0]       nl_run;
  logic             file_start;

  logic [BYTE_W-1:0] burst [MAX_BURST];
  int                burst_len;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic void add_char(input logic [BYTE_W-1:0] c);
    burst[burst_len] = c;
    burst_len++;
  endfunction

  // six BCD digits, blank-padded, then a tab; counter holds at all nines
  function automatic void add_line_number();
    logic [3:0] dig;
    logic       lead;
    logic       saturated;
    logic       carry;
    lead = 1'b1;
    for (int k = NUMBER_DIGITS - 1; k >= 0; k--) begin
      dig = line_num[4*k +: 4];
      if (dig != 4'd0 || k == 0) lead = 1'b0;
      add_char(lead ? CH_SPACE : CH_ZERO + BYTE_W'(dig));
    end
    add_char(CH_TAB);
    saturated = 1'b1;
    for (int k = 0; k < NUMBER_DIGITS; k++) begin
      if (line_num[4*k +: 4] != 4'd9) saturated = 1'b0;
    end
    carry = !saturated;
    for (int k = 0; k < NUMBER_DIGITS; k++) begin
      if (carry) begin
        if (line_num[4*k +: 4] == 4'd9) begin
          line_num[4*k +: 4] = 4'd0;
        end else begin
          line_num[4*k +: 4] = line_num[4*k +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end
  endfunction

  function automatic void format_input(input logic op, input logic [BYTE_W-1:0] c);
    logic [2:0] prior;
    logic [6:0] low7;
    burst_len = 0;
    if (op == OP_NEW_FILE) begin
      line_num   = LINE_ONE;
      nl_run     = 2'd0;
      file_start = 1'b1;
      return;
    end
    // start of file acts like a preceding newline
    prior = {1'b0, nl_run} + {2'b00, file_start};
    if (c == CH_NL) begin
      if (nl_run != 2'd3) nl_run++;
      if (squeeze_blank && prior >= 3'd2) return;
      if (prior != 3'd0 && number_all && !number_nonblank) add_line_number();
      if (mark_line_end) add_char(CH_DOLLAR);
      add_char(CH_NL);
    end else begin
      nl_run     = 2'd0;
      file_start = 1'b0;
      if (prior != 3'd0 && (number_nonblank || number_all)) add_line_number();
      if (c == CH_TAB) begin
        if (show_tabs) begin
          add_char(CH_CARET);
          add_char(CH_I);
        end else begin
          add_char(CH_TAB);
        end
      end else if (show_nonprinting) begin
        if (c[7]) begin
          add_char(CH_M);
          add_char(CH_DASH);
        end
        low7 = c[6:0];
        if (low7 < 7'd32) begin
          add_char(CH_CARET);
          add_char({1'b0, low7} + 8'd64);
        end else if (low7 == CH_DEL7) begin
          add_char(CH_CARET);
          add_char(CH_QMARK);
        end else begin
          add_char({1'b0, low7});
        end
      end else begin
        add_char(c);
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    out_char_t want;
    if (!rst_n) begin
      number_all       = 1'b0;
      number_nonblank  = 1'b0;
      squeeze_blank    = 1'b0;
      show_nonprinting = 1'b0;
      mark_line_end    = 1'b0;
      show_tabs        = 1'b0;
      line_num         = LINE_ONE;
      nl_run           = 2'd0;
      file_start       = 1'b1;
      expected_chars.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_NUMBER_ALL:       number_all       = cfg_ch.data[0];
          REG_NUMBER_NONBLANK:  number_nonblank  = cfg_ch.data[0];
          REG_SQUEEZE_BLANK:    squeeze_blank    = cfg_ch.data[0];
          REG_SHOW_NONPRINTING: show_nonprinting = cfg_ch.data[0];
          REG_MARK_LINE_END:    mark_line_end    = cfg_ch.data[0];
          REG_SHOW_TABS:        show_tabs        = cfg_ch.data[0];
          default: ;
        endcase
      end
      // pop before push: a char leaving now cannot belong to the item entering now
      if (out_ch.valid && out_ch.ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                    out_ch.out_byte, out_ch.last));
        end else begin
          want = expected_chars.pop_front();
          if (out_ch.out_byte !== want.ch)
            report_mismatch($sformatf("char %0d: byte 0x%02h, want 0x%02h",
                                      chars_checked, out_ch.out_byte, want.ch));
          if (out_ch.last !== want.last)
            report_mismatch($sformatf("char %0d: last %0b, want %0b",
                                      chars_checked, out_ch.last, want.last));
          chars_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        format_input(in_ch.op, in_ch.byte_in);
        for (int k = 0; k < burst_len; k++)
          expected_chars.push_back('{ch: burst[k], last: (k == burst_len - 1)});
      end
    end
    outstanding <= expected_chars.size();
  end

endmodule

@@ sim/tb_cat_text_stream_formatter.sv @@
`timescale 1ns / 100ps

module tb_cat_text_stream_formatter;
  import cft_pkg::*;

  // indexes past the register list; writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int IDLE_PCT     = 35;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 300;
  localparam int COUNT_LINES  = 24;
  localparam int PHASE_ITEMS  = 14;
  localparam int BURST_ITEMS  = 28;

  typedef struct packed {
    logic show_tabs;
    logic mark_line_end;
    logic show_nonprinting;
    logic squeeze_blank;
    logic number_nonblank;
    logic number_all;
  } fmt_cfg_t;

  logic clk = 1'b0;
  logic rst_n;
  logic out_idle;
  bit   in_idle;
  int   stall_reqs;
  int   items_sent;
  int   settings_applied;
  int   mismatches;
  int   outstanding;
  int   chars_checked;

  cft_in_if  in_ch();
  cft_out_if out_ch();
  cft_cfg_if cfg_ch();

  cat_text_stream_formatter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  cft_stream_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .chars_checked (chars_checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // receiver: random backpressure, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_reqs != holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(out_idle && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  task automatic send_item(input logic op, input logic [BYTE_W-1:0] c);
    while (in_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid   <= 1'b0;
      in_ch.byte_in <= BYTE_W'($urandom);
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.byte_in <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_char(input logic [BYTE_W-1:0] c);
    send_item(OP_DATA, c);
  endtask

  function automatic logic [BYTE_W-1:0] rand_char();
    int pick;
    pick = $urandom_range(99);
    if (pick < 28)      return CH_NL;
    else if (pick < 36) return CH_TAB;
    else if (pick < 70) return BYTE_W'($urandom_range(32, 126));
    else if (pick < 85) return BYTE_W'($urandom_range(0, 255));
    else if (pick < 93) return BYTE_W'($urandom_range(128, 159));
    else                return BYTE_W'($urandom_range(0, 31));
  endfunction

  task automatic run_text(input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 3) send_item(OP_NEW_FILE, BYTE_W'($urandom));
      else send_char(rand_char());
    end
  endtask

  // wait for all predicted chars, then for items that produce nothing
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic apply_setting(input fmt_cfg_t s);
    write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(REG_NUMBER_ALL, s.number_all);
    write_reg(REG_NUMBER_NONBLANK, s.number_nonblank);
    write_reg(REG_SQUEEZE_BLANK, s.squeeze_blank);
    write_reg(REG_SHOW_NONPRINTING, s.show_nonprinting);
    write_reg(REG_MARK_LINE_END, s.mark_line_end);
    write_reg(REG_SHOW_TABS, s.show_tabs);
    write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;
    settings_applied++;
  endtask

  initial begin : stimulus
    fmt_cfg_t setting;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.op       <= OP_DATA;
    in_ch.byte_in  <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= REG_NUMBER_ALL;
    cfg_ch.data    <= '0;
    out_idle       <= 1'b1;
    stall_reqs     <= 0;
    in_idle        = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every decoration on: numbering, squeeze, caret/M- notation, $ and ^I
    apply_setting('{show_tabs: 1'b1, mark_line_end: 1'b1, show_nonprinting: 1'b1,
                    squeeze_blank: 1'b1, number_nonblank: 1'b0, number_all: 1'b1});
    send_char(CH_NL);
    send_char(CH_NL);                  // squeezed at file start
    send_char(CH_NL);
    send_char(8'h41);
    send_char(CH_TAB);
    send_char(8'h00);
    send_char(8'h1F);
    send_char(8'h7F);
    send_char(8'h80);
    send_char(8'h9F);
    send_char(8'hA0);
    send_char(8'hFF);
    send_char(8'h7E);
    send_char(8'h20);
    send_char(CH_NL);
    send_char(CH_NL);
    send_char(CH_NL);
    send_char(CH_NL);                  // newline run saturates
    send_item(OP_NEW_FILE, 8'hFF);
    send_char(CH_NL);
    send_char(8'h78);
    send_char(CH_NL);
    wait_quiet();

    // nonblank numbering overrides number-all; raw bytes pass untouched
    apply_setting('{show_tabs: 1'b0, mark_line_end: 1'b0, show_nonprinting: 1'b0,
                    squeeze_blank: 1'b0, number_nonblank: 1'b1, number_all: 1'b1});
    send_char(CH_NL);
    send_char(CH_NL);
    send_char(CH_TAB);
    send_char(8'h80);
    send_char(CH_NL);
    wait_quiet();

    // run of numbered blank lines, carries the counter into two digits
    apply_setting('{show_tabs: 1'b0, mark_line_end: 1'b0, show_nonprinting: 1'b0,
                    squeeze_blank: 1'b0, number_nonblank: 1'b0, number_all: 1'b1});
    in_idle = 1'b0;
    out_idle <= 1'b0;
    repeat (COUNT_LINES) send_char(CH_NL);
    send_char(8'h61);
    send_item(OP_NEW_FILE, 8'h00);
    in_idle = 1'b1;
    out_idle <= 1'b1;

    for (int p = 0; p < 5; p++) begin
      wait_quiet();
      if (p == 0)      setting = '0;
      else if (p == 1) setting = '1;
      else             setting = fmt_cfg_t'(6'($urandom_range(0, 63)));
      apply_setting(setting);
      run_text(PHASE_ITEMS);
      if (p == 2) begin
        // receiver holds off while the sender keeps offering transfers
        in_idle = 1'b0;
        stall_reqs <= stall_reqs + 1;
        run_text(BURST_ITEMS);
        in_idle = 1'b1;
      end
    end
    wait_quiet();

    $display("ran %0d input items through %0d register settings, %0d output chars checked",
             items_sent, settings_applied, chars_checked);
    $display("line counter carried into two digits; receiver held off %0d cycles under load",
             HOLD_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
